@@ hw/rtl/adc_event_block_unpacker_unit_macros.svh @@
// Assertion macros for the ADC event block unpacker.
// Expects clk and rst_n in the scope of use.
`ifndef ADC_EVENT_BLOCK_UNPACKER_UNIT_MACROS_SVH
`define ADC_EVENT_BLOCK_UNPACKER_UNIT_MACROS_SVH

// same-cycle implication
`define AEBU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aebu assertion failed");

// next-cycle implication
`define AEBU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aebu assertion failed");

`endif

@@ hw/rtl/aebu_pkg.sv @@
// Package of the ADC event block unpacker: result kinds, register map, shared types.
// No dependencies.
package aebu_pkg;

  localparam int WordW  = 16;
  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_DONE_OK  = 2'd1,
    KIND_DONE_BAD = 2'd2,
    KIND_SUPPR    = 2'd3
  } kind_t;

  // register index is paddr[2]
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_ADDR   = 1'b1;

  typedef struct packed {
    logic       format_select;
    logic [7:0] expected_address;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  channel;
    logic [11:0] sample_value;
    logic [15:0] event_counter;
    logic [7:0]  found_address;
  } res_t;

endpackage

@@ hw/rtl/aebu_regs.sv @@
// Configuration registers of the ADC event block unpacker, APB-style access.
// Depends on aebu_pkg.
module aebu_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aebu_pkg::PaddrW-1:0] paddr,
  input  logic [aebu_pkg::PdataW-1:0] pwdata,
  output logic [aebu_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output aebu_pkg::cfg_t             cfg
);
  import aebu_pkg::*;

  logic       format_r;
  logic [7:0] exp_addr_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r   <= 1'b0;
      exp_addr_r <= 8'd0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_FORMAT: format_r   <= pwdata[0];
        REG_ADDR:   exp_addr_r <= pwdata[7:0];
        default:    format_r   <= format_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FORMAT: prdata = {{(PdataW-1){1'b0}}, format_r};
      REG_ADDR:   prdata = {{(PdataW-8){1'b0}}, exp_addr_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.format_select    = format_r;
  assign cfg.expected_address = exp_addr_r;

endmodule

@@ hw/rtl/aebu_inreg.sv @@
// Input word register of the ADC event block unpacker.
// Depends on aebu_pkg.
module aebu_inreg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [aebu_pkg::WordW-1:0] in_word,
  input  logic                      advance,
  output logic                      word_valid,
  output logic [aebu_pkg::WordW-1:0] word
);
  import aebu_pkg::*;

  logic             valid_r;
  logic [WordW-1:0] word_r;

  assign in_ready   = !valid_r || advance;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

@@ hw/rtl/aebu_core.sv @@
// Block format decoder of the ADC event block unpacker: phase state and one-word decode.
// Depends on aebu_pkg.
module aebu_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic [aebu_pkg::WordW-1:0] word,
  input  aebu_pkg::cfg_t            cfg,
  output logic                      res_valid,
  output aebu_pkg::res_t            res
);
  import aebu_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD1   = 3'd0,
    PH_HEAD2   = 3'd1,
    PH_DATA    = 3'd2,
    PH_COUNTER = 3'd3,
    PH_TRAILER = 3'd4,
    PH_SKIP    = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [12:0] words_left_r, words_left_nxt;
  logic [11:0] held_r, held_nxt;
  logic        mismatch_r, mismatch_nxt;
  logic [7:0]  haddr_r, haddr_nxt;
  logic [15:0] counter_r, counter_nxt;
  logic [1:0]  trailer_r, trailer_nxt;
  logic [11:0] qdc_n;
  logic [12:0] words_dec;
  logic [1:0]  trailer_dec;
  logic [7:0]  addr_dec;

  assign qdc_n       = word[11:0];
  assign words_dec   = words_left_r - 13'd1;
  assign trailer_dec = trailer_r - 2'd1;
  assign addr_dec    = cfg.format_select ? word[7:0] : {3'b000, word[15:11]};

  always_comb begin
    phase_nxt      = phase_r;
    words_left_nxt = words_left_r;
    held_nxt       = held_r;
    mismatch_nxt   = mismatch_r;
    haddr_nxt      = haddr_r;
    counter_nxt    = counter_r;
    trailer_nxt    = trailer_r;
    res_valid      = 1'b0;
    res            = '0;
    unique case (phase_r)
      PH_HEAD1: begin
        if (word == 16'hffff) begin
          phase_nxt = PH_SKIP;
        end else begin
          phase_nxt = PH_HEAD2;
          if (!cfg.format_select) begin
            words_left_nxt = {4'b0000, word[15:8], 1'b0};
          end else if (qdc_n == 12'd0) begin
            words_left_nxt = 13'd0;
          end else begin
            words_left_nxt = {qdc_n, 1'b0} - 13'd2;
          end
        end
      end
      PH_HEAD2: begin
        haddr_nxt    = addr_dec;
        mismatch_nxt = (addr_dec != cfg.expected_address);
        phase_nxt    = (words_left_r == 13'd0) ? PH_COUNTER : PH_DATA;
      end
      PH_DATA: begin
        if (!words_left_r[0]) begin
          held_nxt = word[11:0];
        end else if (!mismatch_r) begin
          res_valid        = 1'b1;
          res.kind         = KIND_SAMPLE;
          res.channel      = word[4:0];
          res.sample_value = held_r;
        end
        words_left_nxt = words_dec;
        if (words_dec == 13'd0) begin
          phase_nxt = PH_COUNTER;
        end
      end
      PH_COUNTER: begin
        counter_nxt = word;
        trailer_nxt = 2'd3;
        phase_nxt   = PH_TRAILER;
      end
      PH_TRAILER: begin
        trailer_nxt = trailer_dec;
        if (trailer_dec == 2'd0) begin
          phase_nxt         = PH_HEAD1;
          res_valid         = 1'b1;
          res.kind          = mismatch_r ? KIND_DONE_BAD : KIND_DONE_OK;
          res.event_counter = counter_r;
          res.found_address = haddr_r;
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_HEAD1;
        res_valid = 1'b1;
        res.kind  = KIND_SUPPR;
      end
      default: begin
        phase_nxt = PH_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEAD1;
      words_left_r <= 13'd0;
      held_r       <= 12'd0;
      mismatch_r   <= 1'b0;
      haddr_r      <= 8'd0;
      counter_r    <= 16'd0;
      trailer_r    <= 2'd0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
      held_r       <= held_nxt;
      mismatch_r   <= mismatch_nxt;
      haddr_r      <= haddr_nxt;
      counter_r    <= counter_nxt;
      trailer_r    <= trailer_nxt;
    end
  end

endmodule

@@ hw/rtl/aebu_outreg.sv @@
// Result register of the ADC event block unpacker.
// Depends on aebu_pkg.
module aebu_outreg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  aebu_pkg::res_t res,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output aebu_pkg::res_t out_res
);
  import aebu_pkg::*;

  logic valid_r;
  res_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

@@ hw/rtl/adc_event_block_unpacker_unit.sv @@
// Top level of the ADC event block unpacker: input register, decoder, result register, config.
// Depends on aebu_pkg, aebu_regs, aebu_inreg, aebu_core, aebu_outreg and the macros header.
//
// Decodes the word stream of one readout module's data block, type-A ADC or type-B QDC
// format as set by the format register, and emits sample, done and suppressed words.
// One input word is taken every cycle unless the result side stalls; a word's result, if any,
// shows on out_valid once registered (one decode step from the input register into the result
// register), set by the single decode state machine that handles one word per cycle. A stall on
// the result side holds one word in the input register before in_ready drops. Registers: 0x0
// format_select, 0x4 expected_address; write them only while the block is idle.
`include "adc_event_block_unpacker_unit_macros.svh"

module adc_event_block_unpacker_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aebu_pkg::PaddrW-1:0] paddr,
  input  logic [aebu_pkg::PdataW-1:0] pwdata,
  output logic [aebu_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [4:0]                 out_channel,
  output logic [11:0]                out_sample_value,
  output logic [15:0]                out_event_counter,
  output logic [7:0]                 out_found_address
);
  import aebu_pkg::*;

  cfg_t             cfg;
  logic             word_valid;
  logic [WordW-1:0] word;
  logic             space;
  logic             advance;
  logic             res_valid;
  res_t             res;
  res_t             out_res;

  assign advance = word_valid && space;

  aebu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aebu_inreg u_inreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  aebu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .word      (word),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  aebu_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_channel       = out_res.channel;
  assign out_sample_value  = out_res.sample_value;
  assign out_event_counter = out_res.event_counter;
  assign out_found_address = out_res.found_address;

  `AEBU_ASSERT_NEXT(a_load_shows, advance && res_valid, out_valid)
  `AEBU_ASSERT_NOW(a_no_overrun, out_valid && !out_ready, !advance)
  `AEBU_ASSERT_NOW(a_sample_fields, out_valid && out_kind == KIND_SAMPLE, out_event_counter == 16'd0 && out_found_address == 8'd0)
  `AEBU_ASSERT_NOW(a_done_fields, out_valid && out_kind != KIND_SAMPLE, out_channel == 5'd0 && out_sample_value == 12'd0)

endmodule
